[sv/rwca_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths, codes and reset values for the ring window averager.
// No dependencies; the design files refer to this package by scoped names and the bench imports it.
package rwca_pkg;

  // Store geometry
  localparam int RING_DEPTH  = 64;
  localparam int SAMPLE_BITS = 15;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int CNT_W       = $clog2(RING_DEPTH + 1);
  localparam int ENTRY_W     = 2 * SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] MID_SCALE =
    SAMPLE_BITS'(((1 << SAMPLE_BITS) - 8) / 2);

  // Port field widths
  localparam int RAW_W     = 15;
  localparam int COUNT_W   = 16;
  localparam int MODE_W    = 2;
  localparam int REG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 48;

  // Datapath widths
  localparam int FRAC    = 16;
  localparam int VOLT_W  = SAMPLE_BITS + REG_W - FRAC;
  localparam int DIFF_W  = REG_W + 1;
  localparam int PROD_W  = DIFF_W + REG_W;
  localparam int TERM_W  = PROD_W - FRAC;
  localparam int ACC_W   = TERM_W + CNT_W;
  localparam int STEP_W  = $clog2(ACC_W + 1);

  // Cycles from the last ring read to the last accumulate
  localparam logic [CNT_W-1:0] PIPE_LAT = CNT_W'(3);

  // Codes
  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_ERR  = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_RAW  = 2'd0,
    MODE_VOLT = 2'd1,
    MODE_AMP  = 2'd2,
    MODE_BAD  = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_PER_LSB   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_VOLT_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_VOLT_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_PER_VOLT_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_PER_VOLT_B = 3'd4;

  localparam logic [REG_W-1:0] RST_VOLT_PER_LSB = 32'd432610;
  localparam logic [REG_W-1:0] RST_ZERO_VOLT    = 32'd108134;
  localparam logic [REG_W-1:0] RST_AMP_PER_VOLT = 32'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_sample;
    logic start_req;
    logic rd_issue;
    logic div_start;
    logic load_out;
    logic load_err;
  } rwca_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
  } rwca_sts_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
    if (c > COUNT_W'(RING_DEPTH)) begin
      return CNT_W'(RING_DEPTH);
    end
    return c[CNT_W-1:0];
  endfunction

endpackage

[sv/rwca_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on rwca_pkg for field widths.
interface rwca_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [rwca_pkg::RAW_W-1:0]       raw_a;
  logic [rwca_pkg::RAW_W-1:0]       raw_b;
  logic [rwca_pkg::COUNT_W-1:0]     window_count;
  logic [rwca_pkg::MODE_W-1:0]      result_mode;

  modport source (output valid, action, raw_a, raw_b, window_count, result_mode,
                  input ready);
  modport sink (input valid, action, raw_a, raw_b, window_count, result_mode,
                output ready);
endinterface

interface rwca_out_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic signed [rwca_pkg::OUT_W-1:0] mean_a;
  logic signed [rwca_pkg::OUT_W-1:0] mean_b;

  modport source (output valid, status, mean_a, mean_b, input ready);
  modport sink (input valid, status, mean_a, mean_b, output ready);
endinterface

[sv/rwca_div.sv]
`timescale 1ns / 1ps
// Signed-by-unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero and saturating to the output range. Uses rwca_pkg.
module rwca_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [rwca_pkg::ACC_W-1:0]  dividend,
  input  logic [rwca_pkg::CNT_W-1:0]         divisor,
  output logic                               done,
  output logic signed [rwca_pkg::OUT_W-1:0]  quot
);

  logic [rwca_pkg::ACC_W-1:0]  q_r, q_nxt;
  logic [rwca_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [rwca_pkg::CNT_W-1:0]  d_r;
  logic                        neg_r;
  logic [rwca_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;

  logic [rwca_pkg::CNT_W:0]    rem_sh;
  logic [rwca_pkg::CNT_W:0]    rem_sub;
  logic                        ge;
  logic [rwca_pkg::ACC_W-1:0]  mag;
  logic [rwca_pkg::ACC_W-1:0]  sq;
  logic                        ovf;

  assign mag = dividend[rwca_pkg::ACC_W-1] ? -dividend : dividend;

  // Shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, q_r[rwca_pkg::ACC_W-1]};
  assign ge      = (rem_sh >= {1'b0, d_r});
  assign rem_sub = rem_sh - {1'b0, d_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = mag;
      rem_nxt  = '0;
      step_nxt = rwca_pkg::STEP_W'(rwca_pkg::ACC_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt    = {q_r[rwca_pkg::ACC_W-2:0], ge};
      rem_nxt  = ge ? rem_sub[rwca_pkg::CNT_W-1:0] : rem_sh[rwca_pkg::CNT_W-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == rwca_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      d_r   <= divisor;
      neg_r <= dividend[rwca_pkg::ACC_W-1];
    end
  end

  // Restore the sign, then clamp to the 48-bit signed range
  assign sq  = neg_r ? -q_r : q_r;
  assign ovf = (sq[rwca_pkg::ACC_W-1:rwca_pkg::OUT_W-1] != '0) &&
               (sq[rwca_pkg::ACC_W-1:rwca_pkg::OUT_W-1] != '1);

  always_comb begin
    if (!ovf) begin
      quot = sq[rwca_pkg::OUT_W-1:0];
    end else if (sq[rwca_pkg::ACC_W-1]) begin
      quot = {1'b1, {(rwca_pkg::OUT_W-1){1'b0}}};
    end else begin
      quot = {1'b0, {(rwca_pkg::OUT_W-1){1'b1}}};
    end
  end

  assign done = done_r;

endmodule

[sv/rwca_dp.sv]
`timescale 1ns / 1ps
// Datapath: configuration registers, sample ring memory, conversion pipeline,
// accumulators, two divider lanes and the result register. Uses rwca_pkg, rwca_div.
module rwca_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rwca_pkg::rwca_cmd_t                 cmd,
  output rwca_pkg::rwca_sts_t                 sts,
  input  logic                                cfg_we,
  input  logic [rwca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rwca_pkg::REG_W-1:0]          cfg_data,
  input  logic [rwca_pkg::RAW_W-1:0]          raw_a,
  input  logic [rwca_pkg::RAW_W-1:0]          raw_b,
  input  logic [rwca_pkg::COUNT_W-1:0]        window_count,
  input  logic [rwca_pkg::MODE_W-1:0]         result_mode,
  output logic                                status,
  output logic signed [rwca_pkg::OUT_W-1:0]   mean_a,
  output logic signed [rwca_pkg::OUT_W-1:0]   mean_b
);

  localparam int SB = rwca_pkg::SAMPLE_BITS;

  // Configuration
  logic [rwca_pkg::REG_W-1:0] vpl_r, zero_a_r, zero_b_r, gain_a_r, gain_b_r;

  // Ring memory and pointers
  logic [rwca_pkg::ENTRY_W-1:0] ring_mem [rwca_pkg::RING_DEPTH];
  logic [rwca_pkg::RING_DEPTH-1:0] ent_valid_r;
  logic [rwca_pkg::PTR_W-1:0] wp_r, wp_nxt;
  logic [rwca_pkg::PTR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [rwca_pkg::ENTRY_W-1:0] rd_data_r;
  logic                         rd_vld_r;

  // Pipeline valid flags
  logic p0_r, p1_r, p2_r;

  // Request context
  rwca_pkg::mode_t            mode_r;
  logic [rwca_pkg::CNT_W-1:0] div_cnt_r;

  // Stage 1: sample and voltage
  logic [SB-1:0]                 smp_a, smp_b;
  logic [SB+rwca_pkg::REG_W-1:0] pv_a, pv_b;
  logic [SB-1:0]                 raw_a1_r, raw_b1_r;
  logic [rwca_pkg::VOLT_W-1:0]   volt_a1_r, volt_b1_r;

  // Stage 2: current
  logic signed [rwca_pkg::DIFF_W-1:0] diff_a, diff_b;
  logic signed [rwca_pkg::PROD_W-1:0] prod_a, prod_b;
  logic [SB-1:0]                      raw_a2_r, raw_b2_r;
  logic [rwca_pkg::VOLT_W-1:0]        volt_a2_r, volt_b2_r;
  logic [rwca_pkg::TERM_W-1:0]        amp_a2_r, amp_b2_r;

  // Stage 3: accumulate
  logic [rwca_pkg::ACC_W-1:0] term_a, term_b;
  logic [rwca_pkg::ACC_W-1:0] acc_a_r, acc_b_r;
  logic [rwca_pkg::ACC_W-1:0] dvd_a, dvd_b;

  logic                              done_a, done_b;
  logic signed [rwca_pkg::OUT_W-1:0] quot_a, quot_b;
  logic                              status_r;
  logic signed [rwca_pkg::OUT_W-1:0] mean_a_r, mean_b_r;

  function automatic logic [rwca_pkg::PTR_W-1:0] ptr_prev(
    input logic [rwca_pkg::PTR_W-1:0] p);
    if (p == '0) begin
      return rwca_pkg::PTR_W'(rwca_pkg::RING_DEPTH - 1);
    end
    return p - 1'b1;
  endfunction

  function automatic logic [rwca_pkg::PTR_W-1:0] ptr_next(
    input logic [rwca_pkg::PTR_W-1:0] p);
    if (p == rwca_pkg::PTR_W'(rwca_pkg::RING_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpl_r    <= rwca_pkg::RST_VOLT_PER_LSB;
      zero_a_r <= rwca_pkg::RST_ZERO_VOLT;
      zero_b_r <= rwca_pkg::RST_ZERO_VOLT;
      gain_a_r <= rwca_pkg::RST_AMP_PER_VOLT;
      gain_b_r <= rwca_pkg::RST_AMP_PER_VOLT;
    end else if (cfg_we) begin
      case (cfg_index)
        rwca_pkg::CFG_VOLT_PER_LSB:   vpl_r    <= cfg_data;
        rwca_pkg::CFG_ZERO_VOLT_A:    zero_a_r <= cfg_data;
        rwca_pkg::CFG_ZERO_VOLT_B:    zero_b_r <= cfg_data;
        rwca_pkg::CFG_AMP_PER_VOLT_A: gain_a_r <= cfg_data;
        rwca_pkg::CFG_AMP_PER_VOLT_B: gain_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- ring memory ----------------
  assign wp_nxt      = cmd.wr_sample ? ptr_next(wp_r) : wp_r;
  assign rd_addr_nxt = cmd.start_req ? ptr_prev(wp_r) :
                       cmd.rd_issue  ? ptr_prev(rd_addr_r) : rd_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rd_addr_r   <= '0;
      ent_valid_r <= '0;
      p0_r        <= 1'b0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      rd_addr_r <= rd_addr_nxt;
      if (cmd.wr_sample) begin
        ent_valid_r[wp_r] <= 1'b1;
      end
      p0_r <= cmd.rd_issue;
      p1_r <= p0_r;
      p2_r <= p1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sample) begin
      ring_mem[wp_r] <= {SB'(raw_b), SB'(raw_a)};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= ring_mem[rd_addr_r];
      rd_vld_r  <= ent_valid_r[rd_addr_r];
    end
  end

  // ---------------- request context ----------------
  always_ff @(posedge clk) begin
    if (cmd.start_req) begin
      mode_r    <= rwca_pkg::mode_t'(result_mode);
      div_cnt_r <= rwca_pkg::clamp_count(window_count);
    end
  end

  // ---------------- stage 1: voltage ----------------
  // Entries never written read as mid-scale
  assign smp_a = rd_vld_r ? rd_data_r[SB-1:0]  : rwca_pkg::MID_SCALE;
  assign smp_b = rd_vld_r ? rd_data_r[2*SB-1:SB] : rwca_pkg::MID_SCALE;
  assign pv_a  = smp_a * vpl_r;
  assign pv_b  = smp_b * vpl_r;

  always_ff @(posedge clk) begin
    if (p0_r) begin
      raw_a1_r  <= smp_a;
      raw_b1_r  <= smp_b;
      volt_a1_r <= pv_a[rwca_pkg::FRAC +: rwca_pkg::VOLT_W];
      volt_b1_r <= pv_b[rwca_pkg::FRAC +: rwca_pkg::VOLT_W];
    end
  end

  // ---------------- stage 2: current ----------------
  assign diff_a = $signed(rwca_pkg::DIFF_W'(volt_a1_r) - rwca_pkg::DIFF_W'(zero_a_r));
  assign diff_b = $signed(rwca_pkg::DIFF_W'(volt_b1_r) - rwca_pkg::DIFF_W'(zero_b_r));
  assign prod_a = diff_a * $signed(gain_a_r);
  assign prod_b = diff_b * $signed(gain_b_r);

  always_ff @(posedge clk) begin
    if (p1_r) begin
      raw_a2_r  <= raw_a1_r;
      raw_b2_r  <= raw_b1_r;
      volt_a2_r <= volt_a1_r;
      volt_b2_r <= volt_b1_r;
      // Top bits of the product: floor division by 2^16
      amp_a2_r  <= prod_a[rwca_pkg::FRAC +: rwca_pkg::TERM_W];
      amp_b2_r  <= prod_b[rwca_pkg::FRAC +: rwca_pkg::TERM_W];
    end
  end

  // ---------------- stage 3: accumulate ----------------
  always_comb begin
    case (mode_r)
      rwca_pkg::MODE_RAW: begin
        term_a = rwca_pkg::ACC_W'(raw_a2_r);
        term_b = rwca_pkg::ACC_W'(raw_b2_r);
      end
      rwca_pkg::MODE_VOLT: begin
        term_a = rwca_pkg::ACC_W'(volt_a2_r);
        term_b = rwca_pkg::ACC_W'(volt_b2_r);
      end
      rwca_pkg::MODE_AMP: begin
        term_a = {{(rwca_pkg::ACC_W-rwca_pkg::TERM_W){amp_a2_r[rwca_pkg::TERM_W-1]}},
                  amp_a2_r};
        term_b = {{(rwca_pkg::ACC_W-rwca_pkg::TERM_W){amp_b2_r[rwca_pkg::TERM_W-1]}},
                  amp_b2_r};
      end
      default: begin
        term_a = '0;
        term_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.start_req) begin
      acc_a_r <= '0;
      acc_b_r <= '0;
    end else if (p2_r) begin
      acc_a_r <= acc_a_r + term_a;
      acc_b_r <= acc_b_r + term_b;
    end
  end

  // Raw sums become Q16.16 before the divide
  assign dvd_a = (mode_r == rwca_pkg::MODE_RAW) ? (acc_a_r << rwca_pkg::FRAC) : acc_a_r;
  assign dvd_b = (mode_r == rwca_pkg::MODE_RAW) ? (acc_b_r << rwca_pkg::FRAC) : acc_b_r;

  rwca_div u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ($signed(dvd_a)),
    .divisor  (div_cnt_r),
    .done     (done_a),
    .quot     (quot_a)
  );

  rwca_div u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ($signed(dvd_b)),
    .divisor  (div_cnt_r),
    .done     (done_b),
    .quot     (quot_b)
  );

  assign sts.div_done = done_a & done_b;

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.load_err) begin
        status_r <= rwca_pkg::STATUS_ERR;
        mean_a_r <= '0;
        mean_b_r <= '0;
      end else begin
        status_r <= rwca_pkg::STATUS_OK;
        mean_a_r <= quot_a;
        mean_b_r <= quot_b;
      end
    end
  end

  assign status = status_r;
  assign mean_a = mean_a_r;
  assign mean_b = mean_b_r;

endmodule

[sv/rwca_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences sample writes, the ring walk, the divide and the
// result transfer. Uses rwca_pkg state and command types.
module rwca_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            action,
  input  logic [rwca_pkg::COUNT_W-1:0]    window_count,
  input  logic [rwca_pkg::MODE_W-1:0]     result_mode,
  output logic                            in_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rwca_pkg::rwca_cmd_t             cmd,
  input  rwca_pkg::rwca_sts_t             sts
);

  rwca_pkg::state_t           state_r, state_nxt;
  logic [rwca_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       err_r, err_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       in_xfer;
  logic                       bad_req;
  logic                       out_free;

  assign in_xfer  = in_valid && (state_r == rwca_pkg::ST_IDLE);
  assign bad_req  = (window_count == '0) || (result_mode == rwca_pkg::MODE_BAD);
  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    case (state_r)
      rwca_pkg::ST_IDLE: begin
        if (in_xfer && (action == rwca_pkg::ACT_REQUEST)) begin
          if (bad_req) begin
            err_nxt   = 1'b1;
            state_nxt = rwca_pkg::ST_FINISH;
          end else begin
            err_nxt   = 1'b0;
            cnt_nxt   = rwca_pkg::clamp_count(window_count);
            state_nxt = rwca_pkg::ST_WALK;
          end
        end
      end
      rwca_pkg::ST_WALK: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == rwca_pkg::CNT_W'(1)) begin
          cnt_nxt   = rwca_pkg::PIPE_LAT;
          state_nxt = rwca_pkg::ST_DRAIN;
        end
      end
      rwca_pkg::ST_DRAIN: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == rwca_pkg::CNT_W'(1)) begin
          state_nxt = rwca_pkg::ST_DIV_GO;
        end
      end
      rwca_pkg::ST_DIV_GO: begin
        state_nxt = rwca_pkg::ST_DIVIDE;
      end
      rwca_pkg::ST_DIVIDE: begin
        if (sts.div_done) begin
          state_nxt = rwca_pkg::ST_FINISH;
        end
      end
      rwca_pkg::ST_FINISH: begin
        // Hold until the result register is free
        if (out_free) begin
          state_nxt = rwca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rwca_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      rwca_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.wr_sample = in_xfer && (action == rwca_pkg::ACT_SAMPLE);
        cmd.start_req = in_xfer && (action == rwca_pkg::ACT_REQUEST) && !bad_req;
      end
      rwca_pkg::ST_WALK: begin
        cmd.rd_issue = 1'b1;
      end
      rwca_pkg::ST_DIV_GO: begin
        cmd.div_start = 1'b1;
      end
      rwca_pkg::ST_FINISH: begin
        cmd.load_out = out_free;
        cmd.load_err = err_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rwca_pkg::ST_IDLE;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[sv/ring_window_current_averager_unit.sv]
`timescale 1ns / 1ps
// Ring window current averager. Sample transfers are taken back to back while idle.
// A request for N pairs (N clamped to the depth) makes one ring memory read per
// cycle, then passes 3 pipeline stages and a 56-step one-bit-per-cycle
// divider; the next item is taken in the same cycle as its result shows. Rejected
// requests skip the walk and the divide. Synchronous reset restores the control and
// configuration registers and marks every ring entry mid-scale; no clearing pass.
module ring_window_current_averager_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  rwca_in_if.sink                       in_ch,
  rwca_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [rwca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rwca_pkg::REG_W-1:0]    cfg_data
);

  rwca_pkg::rwca_cmd_t cmd;
  rwca_pkg::rwca_sts_t sts;

  rwca_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .action       (in_ch.action),
    .window_count (in_ch.window_count),
    .result_mode  (in_ch.result_mode),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  rwca_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .raw_a        (in_ch.raw_a),
    .raw_b        (in_ch.raw_b),
    .window_count (in_ch.window_count),
    .result_mode  (in_ch.result_mode),
    .status       (out_ch.status),
    .mean_a       (out_ch.mean_a),
    .mean_b       (out_ch.mean_b)
  );

endmodule

[sv/rwca_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the ring window averager, bound to the top level.
// Depends on rwca_pkg for the status codes and the mean width.
module rwca_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_status,
  input logic signed [rwca_pkg::OUT_W-1:0]  out_mean_a,
  input logic signed [rwca_pkg::OUT_W-1:0]  out_mean_b
);

  // A waiting result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_status) && $stable(out_mean_a) && $stable(out_mean_b))
    else $error("result changed while stalled");

  // Rejected requests carry zero means
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == rwca_pkg::STATUS_ERR) |->
      (out_mean_a == '0) && (out_mean_b == '0))
    else $error("error result with nonzero mean");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // No result is produced in the cycle right after an input transfer
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after input transfer");

endmodule

bind ring_window_current_averager_unit rwca_checker u_rwca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_mean_a (out_ch.mean_a),
  .out_mean_b (out_ch.mean_b)
);

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for ring_window_current_averager_unit: sample and window
// requests over valid/ready channels, checked against an in-bench ring model.
// Depends on rwca_pkg and the rwca_in_if / rwca_out_if interfaces.
module testbench;
  import rwca_pkg::*;

  localparam int     CYCLE_LIMIT  = 600000;
  localparam int     QUIET_CYCLES = RING_DEPTH + 70;
  localparam int     PHASE_ITEMS  = 142;
  localparam longint MEAN_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MEAN_MIN     = -MEAN_MAX - 1;
  localparam logic signed [OUT_W-1:0] MID_MEAN  = {17'b0, MID_SCALE, 16'b0};
  localparam logic signed [OUT_W-1:0] HALF_FULL = {18'b0, {RAW_W{1'b1}}, 15'b0};

  typedef struct packed {
    logic               action;
    logic [RAW_W-1:0]   raw_a;
    logic [RAW_W-1:0]   raw_b;
    logic [COUNT_W-1:0] window_count;
    mode_t              result_mode;
  } ring_item_t;

  typedef struct packed {
    logic                    status;
    logic signed [OUT_W-1:0] mean_a;
    logic signed [OUT_W-1:0] mean_b;
  } window_mean_t;

  typedef struct {
    ring_item_t   item;
    bit           known;
    window_mean_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  rwca_in_if  in_ch ();
  rwca_out_if out_ch ();

  ring_window_current_averager_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Ring model and register copies
  logic [RAW_W-1:0]        ring_a [RING_DEPTH];
  logic [RAW_W-1:0]        ring_b [RING_DEPTH];
  logic [PTR_W-1:0]        next_slot;
  logic [REG_W-1:0]        volt_lsb;
  logic [REG_W-1:0]        zero_a;
  logic [REG_W-1:0]        zero_b;
  logic signed [REG_W-1:0] gain_a;
  logic signed [REG_W-1:0] gain_b;

  window_mean_t pending_means[$];
  row_t         directed[$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           cycle_count = 0;
  bit           steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint volts_of(input logic [RAW_W-1:0] raw);
    return longint'((64'(raw) * 64'(volt_lsb)) >> 16);
  endfunction

  function automatic longint amps_of(input logic [RAW_W-1:0] raw,
                                     input logic [REG_W-1:0] zero,
                                     input logic signed [REG_W-1:0] gain);
    longint diff;
    diff = volts_of(raw) - longint'(zero);
    return (diff * longint'(gain)) >>> 16;
  endfunction

  function automatic logic signed [OUT_W-1:0] clip_mean(input longint v);
    if (v > MEAN_MAX) begin
      v = MEAN_MAX;
    end else if (v < MEAN_MIN) begin
      v = MEAN_MIN;
    end
    return v[OUT_W-1:0];
  endfunction

  // Update the ring for a sample; for a request, return the window mean.
  function automatic window_mean_t predict_window_mean(input ring_item_t it,
                                                       output bit answers);
    window_mean_t     res;
    longint           sum_a;
    longint           sum_b;
    int               n;
    int               i;
    logic [PTR_W-1:0] slot;
    res.status = STATUS_ERR;
    res.mean_a = '0;
    res.mean_b = '0;
    answers = (it.action == ACT_REQUEST);
    if (!answers) begin
      ring_a[next_slot] = it.raw_a;
      ring_b[next_slot] = it.raw_b;
      next_slot = next_slot + 1'b1;
      return res;
    end
    if (it.window_count == '0 || it.result_mode == MODE_BAD) begin
      return res;
    end
    n = (it.window_count > COUNT_W'(RING_DEPTH)) ? RING_DEPTH : int'(it.window_count);
    sum_a = 0;
    sum_b = 0;
    for (i = 0; i < n; i++) begin
      // walk backwards from the newest entry
      slot = next_slot - 1'b1 - PTR_W'(i);
      case (it.result_mode)
        MODE_RAW: begin
          sum_a += longint'(ring_a[slot]);
          sum_b += longint'(ring_b[slot]);
        end
        MODE_VOLT: begin
          sum_a += volts_of(ring_a[slot]);
          sum_b += volts_of(ring_b[slot]);
        end
        default: begin
          sum_a += amps_of(ring_a[slot], zero_a, gain_a);
          sum_b += amps_of(ring_b[slot], zero_b, gain_b);
        end
      endcase
    end
    if (it.result_mode == MODE_RAW) begin
      sum_a = sum_a <<< 16;
      sum_b = sum_b <<< 16;
    end
    res.status = STATUS_OK;
    res.mean_a = clip_mean(sum_a / longint'(n));
    res.mean_b = clip_mean(sum_b / longint'(n));
    return res;
  endfunction

  function automatic logic [RAW_W-1:0] rand_reading();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return RAW_W'($urandom_range(0, 2**RAW_W - 1));
    endcase
  endfunction

  function automatic ring_item_t random_item();
    ring_item_t it;
    int         pick;
    it.action = ($urandom_range(0, 99) < 55) ? ACT_SAMPLE : ACT_REQUEST;
    it.raw_a  = rand_reading();
    it.raw_b  = rand_reading();
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      it.window_count = '0;
    end else if (pick < 50) begin
      it.window_count = COUNT_W'($urandom_range(1, 8));
    end else if (pick < 85) begin
      it.window_count = COUNT_W'($urandom_range(9, RING_DEPTH));
    end else begin
      it.window_count = COUNT_W'($urandom_range(RING_DEPTH + 1, 2**COUNT_W - 1));
    end
    it.result_mode = ($urandom_range(0, 99) < 8) ? MODE_BAD : mode_t'($urandom_range(0, 2));
    return it;
  endfunction

  task automatic add_row(input logic act, input logic [RAW_W-1:0] a,
                         input logic [RAW_W-1:0] b, input logic [COUNT_W-1:0] n,
                         input mode_t m, input bit known = 1'b0,
                         input logic st = STATUS_OK,
                         input logic signed [OUT_W-1:0] ma = '0,
                         input logic signed [OUT_W-1:0] mb = '0);
    row_t r;
    r.item = '{act, a, b, n, m};
    r.known = known;
    r.want = '{st, ma, mb};
    directed.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(input ring_item_t it, input bit known, input window_mean_t want);
    window_mean_t predicted;
    bit           answers;
    while (!steady && $urandom_range(0, 99) < 27) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= it.action;
    in_ch.raw_a        <= it.raw_a;
    in_ch.raw_b        <= it.raw_b;
    in_ch.window_count <= it.window_count;
    in_ch.result_mode  <= it.result_mode;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = predict_window_mean(it, answers);
    if (answers) begin
      pending_means.push_back(known ? want : predicted);
    end
    @(negedge clk);
  endtask

  // Block is idle here, so the model copy can follow at once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_VOLT_PER_LSB:   volt_lsb = val;
      CFG_ZERO_VOLT_A:    zero_a   = val;
      CFG_ZERO_VOLT_B:    zero_b   = val;
      CFG_AMP_PER_VOLT_A: gain_a   = val;
      CFG_AMP_PER_VOLT_B: gain_b   = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_means.size() != 0) begin
      @(negedge clk);
    end
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 27);
  end

  always @(posedge clk) begin : check_results
    window_mean_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_means.size() == 0) begin
        note_mismatch($sformatf("unexpected result: status %0d mean_a %0d mean_b %0d",
                                out_ch.status, out_ch.mean_a, out_ch.mean_b));
      end else begin
        want = pending_means.pop_front();
        if (out_ch.status !== want.status || out_ch.mean_a !== want.mean_a ||
            out_ch.mean_b !== want.mean_b) begin
          note_mismatch($sformatf(
            "result %0d: status exp %0d got %0d, mean_a exp %0d got %0d, mean_b exp %0d got %0d",
            results_seen, want.status, out_ch.status, want.mean_a, out_ch.mean_a,
            want.mean_b, out_ch.mean_b));
        end
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stimulus
    int               k;
    int               phase;
    logic [REG_W-1:0] v;
    logic [REG_W-1:0] za;
    logic [REG_W-1:0] zb;
    logic [REG_W-1:0] ga;
    logic [REG_W-1:0] gb;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_SAMPLE;
    in_ch.raw_a        = '0;
    in_ch.raw_b        = '0;
    in_ch.window_count = '0;
    in_ch.result_mode  = MODE_RAW;

    for (k = 0; k < RING_DEPTH; k++) begin
      ring_a[k] = MID_SCALE;
      ring_b[k] = MID_SCALE;
    end
    next_slot = '0;
    volt_lsb  = RST_VOLT_PER_LSB;
    zero_a    = RST_ZERO_VOLT;
    zero_b    = RST_ZERO_VOLT;
    gain_a    = RST_AMP_PER_VOLT;
    gain_b    = RST_AMP_PER_VOLT;

    // Fresh ring holds mid-scale everywhere
    add_row(ACT_REQUEST, '0, '0, 16'd1, MODE_RAW, 1'b1, STATUS_OK, MID_MEAN, MID_MEAN);
    add_row(ACT_REQUEST, '0, '0, 16'd0, MODE_RAW, 1'b1, STATUS_ERR);
    add_row(ACT_REQUEST, '0, '0, 16'd5, MODE_BAD, 1'b1, STATUS_ERR);
    add_row(ACT_REQUEST, '0, '0, '1, MODE_RAW, 1'b1, STATUS_OK, MID_MEAN, MID_MEAN);
    add_row(ACT_REQUEST, '0, '0, 16'd64, MODE_VOLT);
    add_row(ACT_REQUEST, '0, '0, 16'd64, MODE_AMP);
    // Samples carry junk in the request fields
    add_row(ACT_SAMPLE, '1, '0, '1, MODE_BAD);
    add_row(ACT_SAMPLE, '0, '1, 16'd0, MODE_AMP);
    add_row(ACT_REQUEST, '0, '0, 16'd2, MODE_RAW, 1'b1, STATUS_OK, HALF_FULL, HALF_FULL);
    add_row(ACT_REQUEST, '0, '0, 16'd1, MODE_VOLT);
    add_row(ACT_REQUEST, '0, '0, 16'd2, MODE_AMP);
    add_row(ACT_REQUEST, '0, '0, 16'd65, MODE_AMP);
    add_row(ACT_REQUEST, '1, '1, 16'd0, MODE_BAD, 1'b1, STATUS_ERR);
    add_row(ACT_REQUEST, '0, '0, '1, MODE_BAD, 1'b1, STATUS_ERR);
    add_row(ACT_REQUEST, '0, '0, 16'd0, MODE_VOLT, 1'b1, STATUS_ERR);
    add_row(ACT_SAMPLE, 15'd12345, 15'd23456, 16'd3, MODE_RAW);
    add_row(ACT_SAMPLE, '1, '1, 16'd9, MODE_VOLT);
    add_row(ACT_REQUEST, '0, '0, 16'd3, MODE_RAW);
    add_row(ACT_REQUEST, '0, '0, 16'd64, MODE_RAW);
    add_row(ACT_REQUEST, '0, '0, 16'd3, MODE_VOLT);
    add_row(ACT_REQUEST, '0, '0, 16'd1, MODE_AMP);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Writes past the register list must change nothing
    for (k = 1; k <= 3; k++) begin
      write_reg(CFG_IDX_W'(CFG_AMP_PER_VOLT_B + k), '1);
    end
    cfg_we <= 1'b0;

    foreach (directed[k]) begin
      send(directed[k].item, directed[k].known, directed[k].want);
    end

    for (phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: begin
          v = '0; za = '0; zb = '0; ga = '0; gb = '0;
        end
        1: begin
          v = '1; za = '1; zb = '0; ga = 32'h8000_0000; gb = 32'h7FFF_FFFF;
        end
        2: begin
          v = '1; za = '0; zb = '1; ga = 32'h7FFF_FFFF; gb = 32'h8000_0000;
        end
        3: begin
          v  = REG_W'($urandom_range(300000, 600000));
          za = REG_W'($urandom_range(0, 300000));
          zb = REG_W'($urandom_range(0, 300000));
          ga = REG_W'($urandom_range(0, 1 << 21)) - REG_W'(1 << 20);
          gb = REG_W'($urandom_range(0, 1 << 21)) - REG_W'(1 << 20);
        end
        default: begin
          v = $urandom(); za = $urandom(); zb = $urandom(); ga = $urandom(); gb = $urandom();
        end
      endcase
      write_reg(CFG_VOLT_PER_LSB, v);
      write_reg(CFG_ZERO_VOLT_A, za);
      write_reg(CFG_ZERO_VOLT_B, zb);
      write_reg(CFG_AMP_PER_VOLT_A, ga);
      write_reg(CFG_AMP_PER_VOLT_B, gb);
      write_reg(CFG_IDX_W'(CFG_AMP_PER_VOLT_B + $urandom_range(1, 3)), $urandom());
      cfg_we <= 1'b0;
      // one phase runs with both sides always ready
      steady <= (phase == 3);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        send(random_item(), 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
